[rtl/dma_pkg.sv]
// Package with the shared constants and types of the decimated moving average block.
`timescale 1ns / 1ps
package dma_pkg;
  localparam int unsigned WindowMaxDefault  = 1024;
  localparam int unsigned AlarmCountDefault = 4;
  localparam int unsigned SampleW = 32;
  localparam int unsigned StatusW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegTickPeriod  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWindowLen   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAvgInterval = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAlarmModes  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLevels01    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLevels23    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegHysteresis  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegHoldTime    = 3'd7;

  localparam logic [1:0] AlmHigh     = 2'd0;
  localparam logic [1:0] AlmLow      = 2'd1;
  localparam logic [1:0] AlmDlyHigh  = 2'd2;
  localparam logic [1:0] AlmDlyLow   = 2'd3;

  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic [StatusW-1:0]        alarm_status;
    logic                      average_valid;
  } result_t;
endpackage

[rtl/dma_stream_if.sv]
// Valid/ready stream interface carrying one word per handshake.
`timescale 1ns / 1ps
interface dma_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/decimated_moving_average_alarms.sv]
// Top level of the decimated moving average with four threshold alarms.
//
//   channel   dir   payload                               handshake
//   in_s      in    sample (32b signed)                   valid/ready
//   out_s     out   value, alarm_status, average_valid    valid/ready
//   cfg       in    cfg_we, cfg_idx, cfg_data             write enable only
//
// From acceptance to a loaded result a word passes a 27-step serial divide for the
// push interval, the window update states (push, read, update), a 44-step serial mean
// divide (default window size), and per alarm a check that may use a 16-step serial
// over-time product. With averaging off the divides and window update are skipped.
// Reset is synchronous and clears the control state; window contents are undefined until
// pushed. A word is taken only when the previous result has left the output register.
`timescale 1ns / 1ps
module decimated_moving_average_alarms #(
  parameter int unsigned WINDOW_MAX  = dma_pkg::WindowMaxDefault,
  parameter int unsigned ALARM_COUNT = dma_pkg::AlarmCountDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dma_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [dma_pkg::CfgDataW-1:0]   cfg_data,
  dma_stream_if.sink                     in_s,
  dma_stream_if.source                   out_s
);
  import dma_pkg::*;

  localparam int unsigned PosW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LenW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SumW = SampleW + LenW;
  localparam int unsigned DivW = SumW + 1;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StNDiv   = 4'd1;
  localparam logic [3:0] StPush   = 4'd2;
  localparam logic [3:0] StRead   = 4'd3;
  localparam logic [3:0] StUpd    = 4'd4;
  localparam logic [3:0] StMean   = 4'd5;
  localparam logic [3:0] StMeanF  = 4'd6;
  localparam logic [3:0] StAlarm  = 4'd7;
  localparam logic [3:0] StMul    = 4'd8;
  localparam logic [3:0] StAlmEnd = 4'd9;
  localparam logic [3:0] StDone   = 4'd10;

  // Configuration.
  logic [15:0]     tick_period_ms;
  logic [LenW-1:0] window_length;
  logic [15:0]     average_interval_s;
  logic [11:0]     alarm_modes;
  logic [63:0]     levels_first_pair;
  logic [63:0]     levels_second_pair;
  logic [63:0]     hysteresis_words;
  logic [18:0]     hold_time_s;
  logic [35:0]     hold_ms;

  logic [3:0]      state;
  logic [31:0]     tick_count;
  logic [PosW-1:0] write_position;
  logic [LenW-1:0] fill_count;
  logic signed [SumW-1:0] running_sum;
  logic [3:0]      previous_status;
  logic [31:0]     over_time_count [4];
  logic            pushed;

  logic signed [SampleW-1:0] x;
  logic signed [SampleW-1:0] v;
  logic signed [SampleW-1:0] old_word;
  logic signed [SampleW-1:0] window_store [WINDOW_MAX];
  logic                      avg_valid;
  logic [3:0]                status;

  // Shared shift divider/multiplier registers.
  logic [DivW-1:0] rem;
  logic [DivW-1:0] quo;
  logic [DivW-1:0] dvd;
  logic [5:0]      cnt;
  logic            neg;
  logic [1:0]      ai;
  logic [47:0]     prod;
  logic [31:0]     mcand;
  logic [15:0]     mplier;
  logic [47:0]     prod_step;

  logic [15:0] per;
  logic [25:0] ival;
  logic [LenW-1:0] cfg_len_sat;
  logic [DivW-1:0] rem_sh;
  logic [DivW-1:0] div_d;

  result_t res;
  logic    res_valid;

  assign per = (tick_period_ms == 16'd0) ? 16'd1 : tick_period_ms;
  assign ival = ({10'd0, average_interval_s} * 26'd1000 < {10'd0, per})
              ? {10'd0, per} : {10'd0, average_interval_s} * 26'd1000;
  assign hold_ms = {17'd0, hold_time_s} * 36'd1000;
  assign cfg_len_sat = (32'(cfg_data[10:0]) > WINDOW_MAX) ? LenW'(WINDOW_MAX)
                                                         : LenW'(cfg_data[10:0]);

  // Divider step: state StNDiv divides ival+per-1 by per, StMean divides |sum| plus half the fill by fill.
  assign div_d = (state == StNDiv) ? DivW'(per) : DivW'(fill_count);
  assign rem_sh = {rem[DivW-2:0], dvd[DivW-1]};

  assign prod_step = mplier[0] ? (prod >> 1) + {1'b0, mcand, 15'd0} : (prod >> 1);

  assign in_s.ready = (state == StIdle) && !res_valid;
  assign out_s.valid = res_valid;
  assign out_s.data = res;

  always_ff @(posedge clk) begin
    if (state == StPush) begin
      old_word <= window_store[write_position];
    end
    if (state == StUpd && pushed) begin
      window_store[write_position] <= x;
    end
  end

  // Alarm evaluation helpers for the current alarm index.
  logic [2:0]         mode;
  logic signed [32:0] lvl;
  logic signed [32:0] hys;
  logic signed [32:0] vx;
  logic               prev;
  logic               cond;
  logic [31:0]        cnt_sat;
  always_comb begin
    mode = alarm_modes[3*ai +: 3];
    lvl = (ai < 2'd2) ? 33'(signed'(levels_first_pair[32*ai[0] +: 32]))
                      : 33'(signed'(levels_second_pair[32*ai[0] +: 32]));
    hys = 33'(signed'({17'd0, hysteresis_words[16*ai +: 16]}));
    vx = 33'(v);
    prev = previous_status[ai];
    cond = (mode[2:1] == AlmDlyHigh) ? (vx > lvl) : (vx < lvl);
    cnt_sat = (over_time_count[ai] == 32'hFFFF_FFFF) ? over_time_count[ai]
                                                    : over_time_count[ai] + 32'd1;
  end

  // Magnitude of the updated sum plus half the divisor, for round-to-nearest.
  logic signed [SumW-1:0] sum_after;
  logic                   running_sum_next_neg;
  logic [SumW:0]          sum_abs_next;
  logic [LenW-1:0]        fill_after;
  always_comb begin
    if (pushed && fill_count >= window_length)
      sum_after = running_sum - SumW'(old_word) + SumW'(x);
    else if (pushed)
      sum_after = running_sum + SumW'(x);
    else
      sum_after = running_sum;
    fill_after = (pushed && fill_count < window_length) ? fill_count + 1'b1 : fill_count;
    running_sum_next_neg = sum_after[SumW-1];
    sum_abs_next = (running_sum_next_neg ? (SumW+1)'(-sum_after) : (SumW+1)'(sum_after))
                 + (SumW+1)'(fill_after >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms <= 16'd1000;
      window_length <= '0;
      average_interval_s <= '0;
      alarm_modes <= '0;
      levels_first_pair <= '0;
      levels_second_pair <= '0;
      hysteresis_words <= '0;
      hold_time_s <= '0;
      state <= StIdle;
      tick_count <= '0;
      write_position <= '0;
      fill_count <= '0;
      running_sum <= '0;
      previous_status <= '0;
      for (int k = 0; k < 4; k++) over_time_count[k] <= '0;
      res_valid <= 1'b0;
    end else begin
      if (out_s.valid && out_s.ready) res_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          RegTickPeriod:  tick_period_ms <= cfg_data[15:0];
          RegWindowLen:   window_length <= cfg_len_sat;
          RegAvgInterval: average_interval_s <= cfg_data[15:0];
          RegAlarmModes:  alarm_modes <= cfg_data[11:0];
          RegLevels01:    levels_first_pair <= cfg_data;
          RegLevels23:    levels_second_pair <= cfg_data;
          RegHysteresis:  hysteresis_words <= cfg_data;
          RegHoldTime:    hold_time_s <= cfg_data[18:0];
          default: ;
        endcase
        tick_count <= '0;
        write_position <= '0;
        fill_count <= '0;
        running_sum <= '0;
        for (int k = 0; k < 4; k++) over_time_count[k] <= '0;
      end else begin
        unique case (state)
          StIdle: begin
            if (in_s.valid && in_s.ready) begin
              x <= in_s.data;
              v <= in_s.data;
              avg_valid <= 1'b0;
              status <= '0;
              ai <= '0;
              if (window_length != '0) begin
                dvd <= DivW'(ival + 26'(per) - 26'd1) << (DivW - 27);
                rem <= '0;
                quo <= '0;
                cnt <= 6'd27;
                state <= StNDiv;
              end else begin
                state <= StAlarm;
              end
            end
          end
          StNDiv, StMean: begin
            dvd <= dvd << 1;
            if (rem_sh >= div_d) begin
              rem <= rem_sh - div_d;
              quo <= {quo[DivW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[DivW-2:0], 1'b0};
            end
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) state <= (state == StNDiv) ? StPush : StMeanF;
          end
          StPush: begin
            if (33'(tick_count) + 33'd1 >= 33'(quo)) begin
              tick_count <= '0;
              pushed <= 1'b1;
              state <= StRead;
            end else begin
              tick_count <= tick_count + 32'd1;
              pushed <= 1'b0;
              state <= StUpd;
            end
          end
          StRead: state <= StUpd;
          StUpd: begin
            if (pushed) begin
              if (fill_count < window_length) begin
                fill_count <= fill_count + 1'b1;
              end
              running_sum <= sum_after;
              write_position <= (32'(write_position) + 32'd1 >= 32'(window_length))
                              ? '0 : write_position + 1'b1;
            end
            neg <= running_sum_next_neg;
            dvd <= DivW'(sum_abs_next);
            cnt <= 6'(DivW);
            rem <= '0;
            quo <= '0;
            state <= StMean;
          end
          StMeanF: begin
            if (fill_count != '0) begin
              v <= neg ? -SampleW'(quo) : SampleW'(quo);
              avg_valid <= 1'b1;
            end
            state <= StAlarm;
          end
          StAlarm: begin
            if (32'(ai) >= ALARM_COUNT || !mode[0]) begin
              state <= StAlmEnd;
            end else begin
              unique case (mode[2:1])
                AlmHigh: status[ai] <= (vx > lvl) || (prev && vx > lvl - hys);
                AlmLow:  status[ai] <= (vx < lvl) || (prev && vx < lvl + hys);
                default: ;
              endcase
              if (mode[2]) begin
                if (!cond) begin
                  over_time_count[ai] <= '0;
                  state <= StAlmEnd;
                end else begin
                  over_time_count[ai] <= cnt_sat;
                  mcand <= cnt_sat;
                  mplier <= per;
                  prod <= '0;
                  cnt <= 6'd16;
                  state <= StMul;
                end
              end else begin
                state <= StAlmEnd;
              end
            end
          end
          StMul: begin
            prod <= prod_step;
            mplier <= mplier >> 1;
            cnt <= cnt - 6'd1;
            if (cnt == 6'd1) begin
              state <= StAlmEnd;
              status[ai] <= prod_step > 48'(hold_ms);
            end
          end
          StAlmEnd: begin
            if (ai == 2'd3) begin
              state <= StDone;
            end else begin
              ai <= ai + 2'd1;
              state <= StAlarm;
            end
          end
          StDone: begin
            previous_status <= status;
            res.value <= v;
            res.alarm_status <= status;
            res.average_valid <= avg_valid;
            res_valid <= 1'b1;
            state <= StIdle;
          end
          default: state <= StIdle;
        endcase
      end
    end
  end

  property p_out_stable;
    @(posedge clk) disable iff (rst) res_valid && !out_s.ready |=> res_valid;
  endproperty
  assert property (p_out_stable) else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst) in_s.ready |-> !res_valid)
    else $error("input taken while result pending");

  assert property (@(posedge clk) disable iff (rst) fill_count <= window_length || cfg_we
                   || $past(cfg_we))
    else $error("fill count beyond window length");
endmodule
